// ===== rtl/dmrw_pkg.sv =====
// Package for the dot-matrix row and frame writer.
// Holds field widths, action and control codes, and store constants.
// No dependencies.
`timescale 1ns / 1ps

package dmrw_pkg;

    // Default number of row-select bits (display rows).
    localparam int ROW_COUNT_DEF = 16;

    // Pixel store geometry.
    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W      = 8;
    localparam int WORD_W      = 32;

    // Input field widths.
    localparam int ACTION_W   = 2;
    localparam int BYTE_W     = 8;
    localparam int PAIR_W     = 2;
    localparam int CTRL_IDX_W = 3;
    localparam int ROW_W      = 4;
    localparam int COL_W      = 7;
    localparam int LEVEL_W    = 2;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 8;

    // Action codes carried in tuser.
    localparam logic [ACTION_W-1:0] ACT_SHIFT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LATCH = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CTRL  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd3;

    // Control bit numbers.
    localparam logic [CTRL_IDX_W-1:0] CTRL_BLANK     = 3'd3;
    localparam logic [CTRL_IDX_W-1:0] CTRL_ROW_DATA  = 3'd5;
    localparam logic [CTRL_IDX_W-1:0] CTRL_ROW_CLOCK = 3'd6;

    // Pixel intensity codes.
    localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_HALF = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 2'd2;

endpackage

// ===== rtl/dot_matrix_row_frame_writer_unit.sv =====
// Dot-matrix column and row engine: column shift and hold registers,
// row-select chain, double-buffered pixel store and pixel read-back.
// Depends on dmrw_pkg.
`timescale 1ns / 1ps

// This block models the column and row logic of a 128 x 16 dot-matrix
// display with two brightness levels. Each input item carries an action in
// s_axis_tuser: a shift item moves one bit pair of the port byte into the two
// 32-bit column shift registers, a latch item copies them into the hold
// registers, a control item drives the blank, row data or row clock bit, and
// a read item returns one pixel's intensity (off, half or full) as a result
// item on the master side; the other actions give no result. Shift, control
// and latch items need no sequencer steps unless they start a row write. A
// row write is run by a small sequencer over a single-port 256 x 32 pixel
// store: it visits every row of the row-select register, makes no store write
// for a row that is not selected and two or four store writes for a selected
// row. A read steps through the current word, the previous word and a result
// step, because its two words come one after the other through the same store
// port. The block is not ready for the next item until the current one is
// done; a read waits in its last step while an earlier result has not been
// taken. The store needs no clearing pass after reset: one flip-flop per word
// marks it as written, and an unwritten word reads as zero.
module dot_matrix_row_frame_writer_unit
    import dmrw_pkg::*;
#(
    parameter int ROW_COUNT = ROW_COUNT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0: port_byte[7:0], port_pair[9:8], control_index[12:10],
    // control_value[13], pixel_row[17:14], pixel_column[24:18], zero fill.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: action[1:0].
    input  logic [ACTION_W-1:0]    s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0: intensity[1:0], zero fill.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int RW = $clog2(ROW_COUNT);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROW_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_RD_CUR,
        ST_RD_OLD,
        ST_RESULT
    } state_t;

    // Unpacked input fields.
    logic [BYTE_W-1:0]     in_byte;
    logic [PAIR_W-1:0]     in_pair;
    logic [CTRL_IDX_W-1:0] in_ctrl_idx;
    logic                  in_ctrl_val;
    logic [ROW_W-1:0]      in_row;
    logic [COL_W-1:0]      in_col;

    assign in_byte     = s_axis_tdata[7:0];
    assign in_pair     = s_axis_tdata[9:8];
    assign in_ctrl_idx = s_axis_tdata[12:10];
    assign in_ctrl_val = s_axis_tdata[13];
    assign in_row      = s_axis_tdata[17:14];
    assign in_col      = s_axis_tdata[24:18];

    // Sequencer and architectural state.
    state_t                 state_reg;
    logic [WORD_W-1:0]      shift_a_reg;
    logic [WORD_W-1:0]      shift_b_reg;
    logic [WORD_W-1:0]      hold_a_reg;
    logic [WORD_W-1:0]      hold_b_reg;
    logic [ROW_COUNT-1:0]   row_sel_reg;
    logic [ROW_COUNT-1:0]   prev_sel_reg;
    logic                   row_data_reg;
    logic                   row_clock_reg;
    logic                   blank_reg;
    logic                   toggle_reg;
    logic [STORE_DEPTH-1:0] word_valid_reg;

    // Row walk bookkeeping.
    logic [RW-1:0]          row_idx_reg;
    logic [1:0]             word_idx_reg;
    logic                   changed_reg;

    // Pixel read bookkeeping.
    logic [ROW_W-1:0]       pix_row_reg;
    logic [COL_W-1:0]       pix_col_reg;
    logic                   cur_bit_reg;

    // Store read port and result register.
    logic [WORD_W-1:0]      rd_data_reg;
    logic                   rd_valid_reg;
    logic                   out_valid_reg;
    logic [LEVEL_W-1:0]     level_reg;

    // Pixel store.
    logic [WORD_W-1:0]      store_mem [STORE_DEPTH];

    logic                   accept;
    logic                   start_walk;
    logic                   toggle_next;
    logic                   shift_bit_a;
    logic                   shift_bit_b;
    logic                   row_hit;
    logic                   last_word;
    logic                   row_done;
    logic                   mem_we;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_addr;
    logic [WORD_W-1:0]      mem_wdata;
    logic [ADDR_W-1:0]      walk_addr;
    logic [ADDR_W-1:0]      pix_addr;
    logic                   rd_bit;
    logic                   out_free;
    logic [LEVEL_W-1:0]     level_next;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(level_reg);
    assign out_free      = !out_valid_reg || m_axis_tready;

    // The chosen bit pair of the port byte: bit 2p feeds register A and
    // bit 2p+1 feeds register B.
    assign shift_bit_a = in_byte[{in_pair, 1'b0}];
    assign shift_bit_b = in_byte[{in_pair, 1'b1}];

    // A row write starts on a latch with blank set, or on blank rising.
    always_comb
    begin
        start_walk = 1'b0;
        if (accept)
        begin
            case (s_axis_tuser)
                ACT_LATCH:
                begin
                    start_walk = blank_reg;
                end
                ACT_CTRL:
                begin
                    start_walk = (in_ctrl_idx == CTRL_BLANK) && in_ctrl_val && !blank_reg;
                end
                default:
                begin
                    start_walk = 1'b0;
                end
            endcase
        end
    end

    // An empty row selection flips the front and back buffers.
    assign toggle_next = (row_sel_reg == '0) ? !toggle_reg : toggle_reg;

    // Row walk: each selected row gets two words, or four when the row
    // selection changed since the previous row write.
    assign row_hit   = row_sel_reg[row_idx_reg];
    assign last_word = changed_reg ? (word_idx_reg == 2'd3) : (word_idx_reg == 2'd1);
    assign row_done  = !row_hit || last_word;

    // Writes go to the back buffer: base 0x80 while the toggle is clear.
    assign walk_addr = {!toggle_reg, 7'(ADDR_W'({row_idx_reg, word_idx_reg}))};

    // Reads use the front buffer; words +0/+1 are current, +2/+3 previous,
    // and the low address bit picks the even or odd column word.
    assign pix_addr  = {toggle_reg, pix_row_reg, pix_col_reg[6],
                        (state_reg == ST_RD_OLD), pix_col_reg[0]};

    assign mem_we    = (state_reg == ST_WALK) && row_hit;
    assign mem_wdata = word_idx_reg[0] ? hold_a_reg : hold_b_reg;
    assign mem_re    = (state_reg == ST_RD_CUR) || (state_reg == ST_RD_OLD);
    assign mem_addr  = (state_reg == ST_WALK) ? walk_addr : pix_addr;

    assign rd_bit    = rd_valid_reg && rd_data_reg[pix_col_reg[5:1]];

    always_comb
    begin
        if (cur_bit_reg != rd_bit)
        begin
            level_next = LEVEL_HALF;
        end
        else if (cur_bit_reg)
        begin
            level_next = LEVEL_FULL;
        end
        else
        begin
            level_next = LEVEL_OFF;
        end
    end

    // Single-port pixel store with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_mem[mem_addr];
        end
    end

    // Sequencer, architectural registers and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            shift_a_reg    <= '0;
            shift_b_reg    <= '0;
            hold_a_reg     <= '0;
            hold_b_reg     <= '0;
            row_sel_reg    <= '0;
            prev_sel_reg   <= '0;
            row_data_reg   <= 1'b0;
            row_clock_reg  <= 1'b0;
            blank_reg      <= 1'b0;
            toggle_reg     <= 1'b0;
            word_valid_reg <= '0;
            row_idx_reg    <= '0;
            word_idx_reg   <= '0;
            changed_reg    <= 1'b0;
            pix_row_reg    <= '0;
            pix_col_reg    <= '0;
            cur_bit_reg    <= 1'b0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            level_reg      <= LEVEL_OFF;
        end
        else
        begin
            // The result step reloads the result register itself.
            if (out_valid_reg && m_axis_tready && (state_reg != ST_RESULT))
            begin
                out_valid_reg <= 1'b0;
            end

            if (mem_we)
            begin
                word_valid_reg[mem_addr] <= 1'b1;
            end
            if (mem_re)
            begin
                rd_valid_reg <= word_valid_reg[mem_addr];
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (s_axis_tuser)
                            ACT_SHIFT:
                            begin
                                shift_a_reg <= {shift_bit_a, shift_a_reg[WORD_W-1:1]};
                                shift_b_reg <= {shift_bit_b, shift_b_reg[WORD_W-1:1]};
                            end
                            ACT_LATCH:
                            begin
                                hold_a_reg <= shift_a_reg;
                                hold_b_reg <= shift_b_reg;
                            end
                            ACT_CTRL:
                            begin
                                case (in_ctrl_idx)
                                    CTRL_BLANK:
                                    begin
                                        blank_reg <= in_ctrl_val;
                                    end
                                    CTRL_ROW_DATA:
                                    begin
                                        row_data_reg <= in_ctrl_val;
                                    end
                                    CTRL_ROW_CLOCK:
                                    begin
                                        // The row-select chain shifts on the
                                        // falling edge of the row clock.
                                        if (!in_ctrl_val && row_clock_reg)
                                        begin
                                            row_sel_reg <= ROW_COUNT'({row_sel_reg,
                                                                       row_data_reg});
                                        end
                                        row_clock_reg <= in_ctrl_val;
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                            default:
                            begin
                                pix_row_reg <= in_row;
                                pix_col_reg <= in_col;
                                state_reg   <= ST_RD_CUR;
                            end
                        endcase

                        if (start_walk)
                        begin
                            toggle_reg   <= toggle_next;
                            changed_reg  <= (prev_sel_reg != row_sel_reg);
                            row_idx_reg  <= '0;
                            word_idx_reg <= '0;
                            state_reg    <= ST_WALK;
                        end
                    end
                end

                ST_WALK:
                begin
                    if (row_done)
                    begin
                        word_idx_reg <= '0;
                        if (row_idx_reg == LAST_ROW)
                        begin
                            prev_sel_reg <= row_sel_reg;
                            state_reg    <= ST_IDLE;
                        end
                        else
                        begin
                            row_idx_reg <= row_idx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        word_idx_reg <= word_idx_reg + 1'b1;
                    end
                end

                ST_RD_CUR:
                begin
                    state_reg <= ST_RD_OLD;
                end

                ST_RD_OLD:
                begin
                    // The current-frame word has arrived; keep its bit.
                    cur_bit_reg <= rd_bit;
                    state_reg   <= ST_RESULT;
                end

                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        level_reg     <= level_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
